FILE: sv/tvnl_pkg.sv
// Shared types, constants and a helper function of the tetrahedron volume engine.
`timescale 1ns / 1ps
`default_nettype none
package tvnl_pkg;
	localparam int NODES_DEF   = 1024;
	localparam int IDX_W       = 10;
	localparam int COORD_W     = 16;
	localparam int DIFF_W      = COORD_W + 1;
	localparam int COF_W       = 2 * DIFF_W + 1;
	localparam int DET_W       = 54;
	localparam int VOL_W       = 50;
	localparam int SUM_W       = 64;
	localparam int CNT_W       = 16;
	localparam int ELEM_W      = 32;
	localparam int VERT_N      = 4;
	localparam int DIM_N       = 3;
	localparam int S_TDATA_W   = 88;
	localparam int S_TUSER_W   = 2;
	localparam int M_TDATA_W   = 296;
	localparam int DIV_SIXTH   = 6;

	// Divide by six in four 14-bit quotient digits. Each digit comes from a
	// reciprocal multiply by ceil(2^18 / 6), exact for dividends below 2^17.
	localparam int DIV6_DIG    = 14;
	localparam int DIV6_W      = 4 * DIV6_DIG;
	localparam int DIV6_NUM_W  = DIV6_DIG + 3;
	localparam int DIV6_RECIP  = 43691;
	localparam int DIV6_SHIFT  = 18;
	localparam int DIV6_PROD_W = DIV6_NUM_W + 16;

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_ELEMENT = 2'd1,
		OP_READ    = 2'd2,
		OP_CLEAR   = 2'd3
	} opcode_t;

	typedef struct packed {
		opcode_t                          op;
		logic [VERT_N-1:0][IDX_W-1:0]     node;
		logic [VERT_N-1:0]                in_range;
		logic signed [COORD_W-1:0]        x;
		logic signed [COORD_W-1:0]        y;
		logic signed [COORD_W-1:0]        z;
	} cmd_t;

	function automatic logic signed [SUM_W-1:0] sat_add64(
		input logic signed [SUM_W-1:0] a,
		input logic signed [SUM_W-1:0] b
	);
		logic signed [SUM_W:0] s;
		s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
		if (s[SUM_W] != s[SUM_W-1]) begin
			return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end
		return s[SUM_W-1:0];
	endfunction
endpackage
`default_nettype wire

FILE: sv/tvnl_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module tvnl_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] addr,
	input  wire logic [W-1:0]         wdata,
	output logic      [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

FILE: sv/tvnl_div.sv
// Restoring divider, one quotient bit per cycle, signed dividend by unsigned divisor.
`timescale 1ns / 1ps
`default_nettype none
module tvnl_div (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic signed [tvnl_pkg::SUM_W-1:0]  dividend,
	input  wire logic        [tvnl_pkg::CNT_W-1:0]  divisor,
	output logic                                    busy,
	output logic                                    done,
	output logic signed      [tvnl_pkg::SUM_W-1:0]  quotient
);
	import tvnl_pkg::*;

	localparam int STEP_W = $clog2(SUM_W);

	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [STEP_W-1:0] step_q;
	logic              neg_q;
	logic              busy_q;
	logic              done_q;
	logic [CNT_W:0]    rem_sh;
	logic              fits;

	assign rem_sh = {rem_q, quo_q[SUM_W-1]};
	assign fits   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend[SUM_W-1] ? -dividend : dividend;
			neg_q <= dividend[SUM_W-1];
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], fits};
			rem_q <= fits ? CNT_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[CNT_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);
endmodule
`default_nettype wire

FILE: sv/tvnl_front.sv
// Input stage: takes words, decodes them into commands and queues them for the engine.
`timescale 1ns / 1ps
`default_nettype none
module tvnl_front #(
	parameter int NODES = tvnl_pkg::NODES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [tvnl_pkg::S_TDATA_W-1:0]    s_tdata,
	input  wire logic [tvnl_pkg::S_TUSER_W-1:0]    s_tuser,
	output logic                                   q_valid,
	output tvnl_pkg::cmd_t                         q_cmd,
	input  wire logic                              q_pop
);
	import tvnl_pkg::*;

	cmd_t       entry_q [2];
	logic [1:0] count_q;
	logic       rd_q;
	logic       wr_q;
	cmd_t       cmd_in;
	logic       push;

	always_comb begin
		cmd_in    = '0;
		cmd_in.op = opcode_t'(s_tuser);
		for (int j = 0; j < VERT_N; j++) begin
			cmd_in.node[j]     = s_tdata[j*IDX_W +: IDX_W];
			cmd_in.in_range[j] = 32'(s_tdata[j*IDX_W +: IDX_W]) < NODES;
		end
		cmd_in.x = s_tdata[40 +: COORD_W];
		cmd_in.y = s_tdata[56 +: COORD_W];
		cmd_in.z = s_tdata[72 +: COORD_W];
	end

	assign s_tready = count_q != 2'd2;
	assign push     = s_tvalid && s_tready;
	assign q_valid  = count_q != 2'd0;
	assign q_cmd    = entry_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rd_q    <= 1'b0;
			wr_q    <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (q_pop) begin
				rd_q <= ~rd_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= cmd_in;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("command queue popped while empty");
endmodule
`default_nettype wire

FILE: sv/tvnl_back.sv
// Engine: node stores, determinant datapath, node updates and the result register.
`timescale 1ns / 1ps
`default_nettype none
module tvnl_back #(
	parameter int NODES = tvnl_pkg::NODES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              q_valid,
	input  wire tvnl_pkg::cmd_t                    q_cmd,
	output logic                                   q_pop,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [tvnl_pkg::M_TDATA_W-1:0]         m_tdata,
	output logic                                   m_tuser
);
	import tvnl_pkg::*;

	localparam int AW = $clog2(NODES);
	localparam int CW = 3 * COORD_W;

	typedef enum logic [13:0] {
		ST_CLEAR   = 14'b00000000000001,
		ST_IDLE    = 14'b00000000000010,
		ST_RD_WAIT = 14'b00000000000100,
		ST_RD_DIV  = 14'b00000000001000,
		ST_E_RD    = 14'b00000000010000,
		ST_E_CAP   = 14'b00000000100000,
		ST_E_DIFF  = 14'b00000001000000,
		ST_E_COF   = 14'b00000010000000,
		ST_E_PROD  = 14'b00000100000000,
		ST_E_SUM   = 14'b00001000000000,
		ST_E_DIV   = 14'b00010000000000,
		ST_V_RD    = 14'b00100000000000,
		ST_V_WR    = 14'b01000000000000,
		ST_E_VOL   = 14'b10000000000000
	} state_t;

	state_t                           state_q;
	logic [AW-1:0]                    clr_q;
	cmd_t                             cmd_q;
	logic [1:0]                       vj_q;
	logic signed [COORD_W-1:0]        p_q [VERT_N][DIM_N];
	logic signed [DIFF_W-1:0]         m_q [DIM_N][DIM_N];
	logic signed [COF_W-1:0]          c_q [DIM_N];
	logic signed [DET_W-1:0]          t_q [DIM_N];
	logic signed [VOL_W-1:0]          vol_q;
	logic signed [SUM_W-1:0]          total_q;
	logic [ELEM_W-1:0]                elems_q;
	logic                             out_valid_q;
	logic signed [VOL_W-1:0]          o_vol_q;
	logic signed [SUM_W-1:0]          o_sum_q;
	logic signed [SUM_W-1:0]          o_avg_q;
	logic [CNT_W-1:0]                 o_uses_q;
	logic                             o_status_q;
	logic [DIV6_W-1:0]                d6_mag_q;
	logic [DIV6_W-1:0]                d6_quo_q;
	logic [2:0]                       d6_rem_q;
	logic                             d6_neg_q;

	logic [AW-1:0]                    addr;
	logic                             crd_we;
	logic [CW-1:0]                    crd_wdata;
	logic [CW-1:0]                    crd_rdata;
	logic                             acc_we;
	logic [SUM_W-1:0]                 sum_wdata;
	logic [SUM_W-1:0]                 sum_rdata;
	logic [CNT_W-1:0]                 cnt_wdata;
	logic [CNT_W-1:0]                 cnt_rdata;
	logic                             div_start;
	logic signed [SUM_W-1:0]          div_dividend;
	logic [CNT_W-1:0]                 div_divisor;
	logic                             div_busy;
	logic                             div_done;
	logic signed [SUM_W-1:0]          div_quo;
	logic signed [DET_W-1:0]          det;
	logic signed [SUM_W-1:0]          vol_ext;
	logic [DIV6_NUM_W-1:0]            d6_num;
	logic [DIV6_PROD_W-1:0]           d6_prod;
	logic [DIV6_DIG-1:0]              d6_digit;
	logic [2:0]                       d6_rem;
	logic signed [VOL_W-1:0]          vol_now;

	assign q_pop   = (state_q == ST_IDLE) && q_valid && !out_valid_q;
	assign det     = t_q[0] - t_q[1] + t_q[2];
	assign vol_ext = SUM_W'(vol_q);

	// Divide by six, most significant digit first: the running remainder (0..5)
	// is joined with the next 14 magnitude bits and split by a reciprocal multiply.
	assign d6_num   = {d6_rem_q, d6_mag_q[DIV6_W-1 -: DIV6_DIG]};
	assign d6_prod  = DIV6_PROD_W'(d6_num) * DIV6_PROD_W'(DIV6_RECIP);
	assign d6_digit = d6_prod[DIV6_SHIFT +: DIV6_DIG];
	assign d6_rem   = 3'(d6_num - DIV6_NUM_W'(d6_digit) * DIV6_NUM_W'(DIV_SIXTH));
	assign vol_now  = VOL_W'(d6_neg_q ? -d6_quo_q : d6_quo_q);

	// Memory address and write controls.
	always_comb begin
		addr      = AW'(cmd_q.node[vj_q]);
		crd_we    = 1'b0;
		acc_we    = 1'b0;
		crd_wdata = {q_cmd.z, q_cmd.y, q_cmd.x};
		sum_wdata = '0;
		cnt_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				addr   = clr_q;
				acc_we = 1'b1;
			end
			ST_IDLE: begin
				addr = AW'(q_cmd.node[0]);
				if (q_pop && q_cmd.op == OP_LOAD && q_cmd.in_range[0]) begin
					crd_we = 1'b1;
					acc_we = 1'b1;
				end
			end
			ST_V_WR: begin
				acc_we    = cmd_q.in_range[vj_q];
				sum_wdata = sat_add64($signed(sum_rdata), vol_ext);
				cnt_wdata = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + 1'b1;
			end
			default: begin
			end
		endcase
	end

	// The serial divider only forms the node average of a read.
	always_comb begin
		div_start    = 1'b0;
		div_dividend = $signed(sum_rdata);
		div_divisor  = cnt_rdata;
		if (state_q == ST_RD_WAIT && cmd_q.in_range[0] && cnt_rdata != '0) begin
			div_start = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			vj_q        <= '0;
			total_q     <= '0;
			elems_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(NODES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_pop) begin
						vj_q <= '0;
						case (q_cmd.op)
							OP_LOAD: begin
								out_valid_q <= 1'b1;
							end
							OP_CLEAR: begin
								total_q     <= '0;
								elems_q     <= '0;
								out_valid_q <= 1'b1;
							end
							OP_READ: begin
								state_q <= ST_RD_WAIT;
							end
							OP_ELEMENT: begin
								state_q <= ST_E_RD;
							end
							default: begin
							end
						endcase
					end
				end
				ST_RD_WAIT: begin
					if (div_start) begin
						state_q <= ST_RD_DIV;
					end else begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_RD_DIV: begin
					if (div_done) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_E_RD: begin
					state_q <= ST_E_CAP;
				end
				ST_E_CAP: begin
					vj_q    <= vj_q + 1'b1;
					state_q <= (vj_q == 2'd3) ? ST_E_DIFF : ST_E_RD;
				end
				ST_E_DIFF: begin
					state_q <= ST_E_COF;
				end
				ST_E_COF: begin
					state_q <= ST_E_PROD;
				end
				ST_E_PROD: begin
					state_q <= ST_E_SUM;
				end
				ST_E_SUM: begin
					vj_q    <= '0;
					state_q <= ST_E_DIV;
				end
				ST_E_DIV: begin
					vj_q <= vj_q + 1'b1;
					if (vj_q == 2'd3) begin
						state_q <= ST_E_VOL;
					end
				end
				ST_E_VOL: begin
					total_q <= sat_add64(total_q, SUM_W'(vol_now));
					if (elems_q != '1) begin
						elems_q <= elems_q + 1'b1;
					end
					vj_q    <= '0;
					state_q <= ST_V_RD;
				end
				ST_V_RD: begin
					state_q <= ST_V_WR;
				end
				ST_V_WR: begin
					vj_q <= vj_q + 1'b1;
					if (vj_q == 2'd3) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						state_q <= ST_V_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath and result payload.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (q_pop) begin
					cmd_q      <= q_cmd;
					o_vol_q    <= '0;
					o_sum_q    <= '0;
					o_avg_q    <= '0;
					o_uses_q   <= '0;
					o_status_q <= 1'b0;
				end
			end
			ST_RD_WAIT: begin
				if (cmd_q.in_range[0]) begin
					o_sum_q  <= $signed(sum_rdata);
					o_uses_q <= cnt_rdata;
				end
				o_status_q <= !div_start;
			end
			ST_RD_DIV: begin
				if (div_done) begin
					o_avg_q <= div_quo;
				end
			end
			ST_E_CAP: begin
				p_q[vj_q][0] <= cmd_q.in_range[vj_q] ? crd_rdata[0 +: COORD_W] : '0;
				p_q[vj_q][1] <= cmd_q.in_range[vj_q] ? crd_rdata[COORD_W +: COORD_W] : '0;
				p_q[vj_q][2] <= cmd_q.in_range[vj_q] ? crd_rdata[2*COORD_W +: COORD_W] : '0;
			end
			ST_E_DIFF: begin
				for (int j = 0; j < DIM_N; j++) begin
					for (int k = 0; k < DIM_N; k++) begin
						m_q[j][k] <= DIFF_W'(p_q[j+1][k]) - DIFF_W'(p_q[0][k]);
					end
				end
			end
			ST_E_COF: begin
				c_q[0] <= COF_W'(m_q[1][1]) * COF_W'(m_q[2][2])
					- COF_W'(m_q[1][2]) * COF_W'(m_q[2][1]);
				c_q[1] <= COF_W'(m_q[1][0]) * COF_W'(m_q[2][2])
					- COF_W'(m_q[1][2]) * COF_W'(m_q[2][0]);
				c_q[2] <= COF_W'(m_q[1][0]) * COF_W'(m_q[2][1])
					- COF_W'(m_q[1][1]) * COF_W'(m_q[2][0]);
			end
			ST_E_PROD: begin
				for (int k = 0; k < DIM_N; k++) begin
					t_q[k] <= DET_W'(m_q[0][k]) * DET_W'(c_q[k]);
				end
			end
			ST_E_SUM: begin
				// Divide the magnitude so that the quotient truncates toward zero.
				d6_mag_q <= DIV6_W'(det[DET_W-1] ? -det : det);
				d6_neg_q <= det[DET_W-1];
				d6_rem_q <= '0;
			end
			ST_E_DIV: begin
				d6_mag_q <= d6_mag_q << DIV6_DIG;
				d6_quo_q <= {d6_quo_q[DIV6_W-DIV6_DIG-1:0], d6_digit};
				d6_rem_q <= d6_rem;
			end
			ST_E_VOL: begin
				vol_q   <= vol_now;
				o_vol_q <= vol_now;
			end
			default: begin
			end
		endcase
	end

	tvnl_ram #(.W(CW), .D(NODES)) u_coord_ram (
		.clk   (clk),
		.we    (crd_we),
		.addr  (addr),
		.wdata (crd_wdata),
		.rdata (crd_rdata)
	);

	tvnl_ram #(.W(SUM_W), .D(NODES)) u_sum_ram (
		.clk   (clk),
		.we    (acc_we),
		.addr  (addr),
		.wdata (sum_wdata),
		.rdata (sum_rdata)
	);

	tvnl_ram #(.W(CNT_W), .D(NODES)) u_cnt_ram (
		.clk   (clk),
		.we    (acc_we),
		.addr  (addr),
		.wdata (cnt_wdata),
		.rdata (cnt_rdata)
	);

	tvnl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign m_tvalid = out_valid_q;
	assign m_tuser  = o_status_q;
	assign m_tdata  = {6'b0, elems_q, o_uses_q, o_avg_q, o_sum_q, total_q, o_vol_q};

	assert property (@(posedge clk) disable iff (!arst_n) div_start |-> !div_busy)
		else $error("divider restarted while busy");
	assert property (@(posedge clk) disable iff (!arst_n) div_done |-> (state_q == ST_RD_DIV))
		else $error("divider finished outside its wait state");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !q_pop && !out_valid_q)
		else $error("command taken during the clearing pass");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready |=> out_valid_q && $stable(m_tdata))
		else $error("result word changed before it was taken");
endmodule
`default_nettype wire

FILE: sv/tetra_volume_node_lumping_top.sv
// Top level of the tetrahedron volume engine with per-node volume lumping.
//
//  Channel | Direction | Handshake           | Contents
//  s_*     | in        | s_tvalid / s_tready | tuser: opcode; tdata: nodes a..d, x, y, z
//  m_*     | out       | m_tvalid / m_tready | tuser: status; tdata: volumes, sums, counts
//
// After reset the block clears the node sum and count stores, one node per cycle;
// words are queued but not executed until that pass ends. A read divides the
// node sum by its count in the 64-step serial divider when the node is in range
// and has uses. An element word is issued, reads its four coordinates, forms the
// determinant (differences, cofactors, products, sum), divides by six one 14-bit
// quotient digit per cycle, restores the sign and updates the total, and then
// updates its four nodes on the single-ported sum and count stores.
// The next word can start in the cycle after the result word is taken, so the
// engine waits while m_tready is low; the two-word queue keeps accepting until
// it is full.
`timescale 1ns / 1ps
`default_nettype none
module tetra_volume_node_lumping_top #(
	parameter int NODES = tvnl_pkg::NODES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// tdata, from bit 0: node_a[10], node_b[10], node_c[10], node_d[10],
	// coord_x[16], coord_y[16], coord_z[16].
	input  wire logic [tvnl_pkg::S_TDATA_W-1:0]    s_tdata,
	// tuser: opcode[2].
	input  wire logic [tvnl_pkg::S_TUSER_W-1:0]    s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// tdata, from bit 0: element_volume[50], total_volume[64], node_sum[64],
	// node_average[64], node_uses[16], elements_done[32], zero fill[6].
	output logic [tvnl_pkg::M_TDATA_W-1:0]         m_tdata,
	// tuser: status[1], set when a read node is out of range or has no uses.
	output logic                                   m_tuser
);
	import tvnl_pkg::*;

	logic q_valid;
	logic q_pop;
	cmd_t q_cmd;

	// Front end: decodes each word and range-checks its node indices.
	tvnl_front #(.NODES(NODES)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_pop    (q_pop)
	);

	// Back end: runs one command at a time and holds the result word.
	tvnl_back #(.NODES(NODES)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);
endmodule
`default_nettype wire
